// ===== design/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and calendar helpers for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WDAY_W  = 18;
  localparam int unsigned R100_W  = 7;
  localparam int unsigned QUO_W   = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
  localparam logic [R100_W-1:0]  RESET_R100  = 7'd0;
  localparam logic [1:0]         RESET_Q4    = 2'd0;
  localparam logic [R100_W-1:0]  R100_LAST   = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;
  localparam int unsigned PROD_W    = YEAR_W + 13;

  typedef enum logic [2:0] {
    MODE_LOAD     = 3'd0,
    MODE_PRE_INC  = 3'd1,
    MODE_POST_INC = 3'd2,
    MODE_PRE_DEC  = 3'd3,
    MODE_POST_DEC = 3'd4,
    MODE_ADD      = 3'd5,
    MODE_SUB      = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV_Q,
    ST_CONV_R,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic conv_q;
    logic conv_r;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_more;
  } status_t;

  function automatic logic is_leap(input logic [1:0] y_lo, input logic [R100_W-1:0] r100,
                                   input logic [1:0] q4);
    logic leap;
    if (r100 == '0) begin
      leap = (q4 == 2'd0);
    end else begin
      leap = (y_lo == 2'd0);
    end
    return leap;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/cds_ctrl.sv =====
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer: accepts an item, runs load conversion, the month walk or (for an
// unused mode) neither, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cds_pkg::status_t  status_i,
  output cds_pkg::cmd_t     cmd_o
);

  cds_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid_i && (state_q == cds_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cds_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            cds_pkg::MODE_LOAD: state_d = cds_pkg::ST_CONV_Q;
            cds_pkg::MODE_PRE_INC, cds_pkg::MODE_POST_INC, cds_pkg::MODE_PRE_DEC,
            cds_pkg::MODE_POST_DEC, cds_pkg::MODE_ADD,
            cds_pkg::MODE_SUB:  state_d = cds_pkg::ST_WALK;
            default:            state_d = cds_pkg::ST_FINISH;
          endcase
        end
      end
      cds_pkg::ST_CONV_Q: state_d = cds_pkg::ST_CONV_R;
      cds_pkg::ST_CONV_R: state_d = cds_pkg::ST_FINISH;
      cds_pkg::ST_WALK: begin
        if (!status_i.walk_more) begin
          state_d = cds_pkg::ST_FINISH;
        end
      end
      cds_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = cds_pkg::ST_IDLE;
        end
      end
      default: state_d = cds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    cmd_o.conv_q  = (state_q == cds_pkg::ST_CONV_Q);
    cmd_o.conv_r  = (state_q == cds_pkg::ST_CONV_R);
    cmd_o.step    = (state_q == cds_pkg::ST_WALK) && status_i.walk_more;
    cmd_o.finish  = (state_q == cds_pkg::ST_FINISH) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cds_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == cds_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/cds_dp.sv =====
// ----------------------------------------------------------------------------
// cds_dp
// Datapath: stored date with year-mod counters, working date, month-walk
// step, load conversion and output register.
// ----------------------------------------------------------------------------
module cds_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cds_pkg::cmd_t                 cmd_i,
  output cds_pkg::status_t              status_o,
  input  logic [2:0]                    mode_i,
  input  logic [cds_pkg::CNT_W-1:0]     day_count_i,
  input  logic [cds_pkg::DAY_W-1:0]     load_day_i,
  input  logic [cds_pkg::MONTH_W-1:0]   load_month_i,
  input  logic [cds_pkg::YEAR_W-1:0]    load_year_i,
  output logic [cds_pkg::DAY_W-1:0]     out_day_o,
  output logic [cds_pkg::MONTH_W-1:0]   out_month_o,
  output logic [cds_pkg::YEAR_W-1:0]    out_year_o,
  output logic                          range_error_o
);

  // stored date
  logic [cds_pkg::DAY_W-1:0]   cur_day_q;
  logic [cds_pkg::MONTH_W-1:0] cur_month_q;
  logic [cds_pkg::YEAR_W-1:0]  cur_year_q;
  logic [cds_pkg::R100_W-1:0]  cur_r100_q;
  logic [1:0]                  cur_q4_q;

  // working date
  logic signed [cds_pkg::WDAY_W-1:0] w_day_q, w_day_d;
  logic [cds_pkg::MONTH_W-1:0]       w_month_q, w_month_d;
  logic [cds_pkg::YEAR_W-1:0]        w_year_q, w_year_d;
  logic [cds_pkg::R100_W-1:0]        w_r100_q, w_r100_d;
  logic [1:0]                        w_q4_q, w_q4_d;
  logic [2:0]                        mode_q;
  logic                              back_q;
  logic                              fail_q, fail_d;
  logic [cds_pkg::QUO_W-1:0]         quo_q;

  logic [cds_pkg::DAY_W-1:0]   out_day_q;
  logic [cds_pkg::MONTH_W-1:0] out_month_q;
  logic [cds_pkg::YEAR_W-1:0]  out_year_q;
  logic                        out_err_q;

  logic [cds_pkg::CNT_W-1:0]         step_n;
  logic                              back_mode;
  logic                              w_leap;
  logic [cds_pkg::DAY_W-1:0]         w_len;
  logic                              walk_more;
  logic [cds_pkg::R100_W-1:0]        inc_r100, dec_r100;
  logic [1:0]                        inc_q4, dec_q4;
  logic [cds_pkg::MONTH_W-1:0]       prev_month;
  logic                              prev_leap;
  logic [cds_pkg::DAY_W-1:0]         prev_len;
  logic [cds_pkg::PROD_W-1:0]        prod;
  logic [cds_pkg::YEAR_W-1:0]        quo_x100;
  logic [cds_pkg::YEAR_W-1:0]        rem100;
  logic                              load_ok;
  logic                              commit;
  logic                              report_new;
  logic                              err;

  always_comb begin
    case (mode_i)
      cds_pkg::MODE_ADD, cds_pkg::MODE_SUB: step_n = day_count_i;
      default:                              step_n = 16'd1;
    endcase
    case (mode_i)
      cds_pkg::MODE_PRE_DEC, cds_pkg::MODE_POST_DEC, cds_pkg::MODE_SUB: back_mode = 1'b1;
      default:                                                           back_mode = 1'b0;
    endcase
  end

  assign w_leap = cds_pkg::is_leap(w_year_q[1:0], w_r100_q, w_q4_q);
  assign w_len  = cds_pkg::month_len(w_month_q, w_leap);

  assign walk_more = !fail_q && (back_q ? (w_day_q <= 0)
                                        : (w_day_q > $signed({13'd0, w_len})));
  assign status_o.walk_more = walk_more;

  assign inc_r100 = (w_r100_q == cds_pkg::R100_LAST) ? '0 : w_r100_q + 7'd1;
  assign inc_q4   = (w_r100_q == cds_pkg::R100_LAST) ? w_q4_q + 2'd1 : w_q4_q;
  assign dec_r100 = (w_r100_q == '0) ? cds_pkg::R100_LAST : w_r100_q - 7'd1;
  assign dec_q4   = (w_r100_q == '0) ? w_q4_q - 2'd1 : w_q4_q;

  // month before the working one; its length uses the year it lies in
  always_comb begin
    if (w_month_q == cds_pkg::MONTH_FIRST) begin
      prev_month = cds_pkg::MONTH_LAST;
      prev_leap  = cds_pkg::is_leap(w_year_q[1:0] - 2'd1, dec_r100, dec_q4);
    end else begin
      prev_month = w_month_q - 4'd1;
      prev_leap  = w_leap;
    end
    prev_len = cds_pkg::month_len(prev_month, prev_leap);
  end

  assign prod     = w_year_q * cds_pkg::RECIP_100;
  assign quo_x100 = {quo_q, 6'd0} + {1'b0, quo_q, 5'd0} + {4'd0, quo_q, 2'd0};
  assign rem100   = w_year_q - quo_x100;

  always_comb begin
    w_day_d   = w_day_q;
    w_month_d = w_month_q;
    w_year_d  = w_year_q;
    w_r100_d  = w_r100_q;
    w_q4_d    = w_q4_q;
    fail_d    = fail_q;
    if (cmd_i.capture) begin
      fail_d = 1'b0;
      if (mode_i == cds_pkg::MODE_LOAD) begin
        w_day_d   = $signed({13'd0, load_day_i});
        w_month_d = load_month_i;
        w_year_d  = load_year_i;
      end else begin
        w_month_d = cur_month_q;
        w_year_d  = cur_year_q;
        w_r100_d  = cur_r100_q;
        w_q4_d    = cur_q4_q;
        if (back_mode) begin
          w_day_d = $signed({13'd0, cur_day_q}) - $signed({2'd0, step_n});
        end else begin
          w_day_d = $signed({13'd0, cur_day_q}) + $signed({2'd0, step_n});
        end
      end
    end else if (cmd_i.conv_r) begin
      w_r100_d = rem100[cds_pkg::R100_W-1:0];
      w_q4_d   = quo_q[1:0];
    end else if (cmd_i.step) begin
      if (back_q) begin
        if (w_month_q == cds_pkg::MONTH_FIRST && w_year_q == '0) begin
          fail_d = 1'b1;
        end else begin
          w_month_d = prev_month;
          w_day_d   = w_day_q + $signed({13'd0, prev_len});
          if (w_month_q == cds_pkg::MONTH_FIRST) begin
            w_year_d = w_year_q - 14'd1;
            w_r100_d = dec_r100;
            w_q4_d   = dec_q4;
          end
        end
      end else begin
        if (w_month_q == cds_pkg::MONTH_LAST && w_year_q >= cds_pkg::YEAR_MAX) begin
          fail_d = 1'b1;
        end else begin
          w_day_d = w_day_q - $signed({13'd0, w_len});
          if (w_month_q == cds_pkg::MONTH_LAST) begin
            w_month_d = cds_pkg::MONTH_FIRST;
            w_year_d  = w_year_q + 14'd1;
            w_r100_d  = inc_r100;
            w_q4_d    = inc_q4;
          end else begin
            w_month_d = w_month_q + 4'd1;
          end
        end
      end
    end
  end

  assign load_ok = (w_month_q >= cds_pkg::MONTH_FIRST) && (w_month_q <= cds_pkg::MONTH_LAST)
                && (w_year_q <= cds_pkg::YEAR_MAX) && (w_day_q >= 1)
                && (w_day_q <= $signed({13'd0, w_len}));

  always_comb begin
    commit     = 1'b0;
    report_new = 1'b0;
    err        = 1'b0;
    case (mode_q)
      cds_pkg::MODE_LOAD: begin
        commit     = load_ok;
        report_new = load_ok;
        err        = !load_ok;
      end
      cds_pkg::MODE_PRE_INC, cds_pkg::MODE_PRE_DEC: begin
        commit     = !fail_q;
        report_new = !fail_q;
        err        = fail_q;
      end
      cds_pkg::MODE_POST_INC, cds_pkg::MODE_POST_DEC: begin
        commit = !fail_q;
        err    = fail_q;
      end
      cds_pkg::MODE_ADD, cds_pkg::MODE_SUB: begin
        report_new = !fail_q;
        err        = fail_q;
      end
      default: begin
        commit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q   <= cds_pkg::RESET_DAY;
      cur_month_q <= cds_pkg::RESET_MONTH;
      cur_year_q  <= cds_pkg::RESET_YEAR;
      cur_r100_q  <= cds_pkg::RESET_R100;
      cur_q4_q    <= cds_pkg::RESET_Q4;
      fail_q      <= 1'b0;
      back_q      <= 1'b0;
      mode_q      <= '0;
    end else begin
      fail_q <= fail_d;
      if (cmd_i.capture) begin
        back_q <= back_mode;
        mode_q <= mode_i;
      end
      if (cmd_i.finish && commit) begin
        cur_day_q   <= w_day_q[cds_pkg::DAY_W-1:0];
        cur_month_q <= w_month_q;
        cur_year_q  <= w_year_q;
        cur_r100_q  <= w_r100_q;
        cur_q4_q    <= w_q4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_day_q   <= w_day_d;
    w_month_q <= w_month_d;
    w_year_q  <= w_year_d;
    w_r100_q  <= w_r100_d;
    w_q4_q    <= w_q4_d;
    if (cmd_i.conv_q) begin
      quo_q <= prod[cds_pkg::RECIP_SH +: cds_pkg::QUO_W];
    end
    if (cmd_i.finish) begin
      out_err_q <= err;
      if (report_new) begin
        out_day_q   <= w_day_q[cds_pkg::DAY_W-1:0];
        out_month_q <= w_month_q;
        out_year_q  <= w_year_q;
      end else begin
        out_day_q   <= cur_day_q;
        out_month_q <= cur_month_q;
        out_year_q  <= cur_year_q;
      end
    end
  end

  assign out_day_o     = out_day_q;
  assign out_month_o   = out_month_q;
  assign out_year_o    = out_year_q;
  assign range_error_o = out_err_q;

endmodule

// ===== design/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date register with load, one-day steps and add/subtract of a
// day count, walked one month per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   day_count, load_day, load_month, load_year   mode
//  m_axis    out  out_day, out_month, out_year                 range_error
//
//  Mode 7 goes from IDLE straight to FINISH; a one-day step with no month
//  change runs IDLE, WALK, FINISH. Load runs IDLE, CONV_Q, CONV_R, FINISH
//  (CONV_Q and CONV_R turn the year into century and remainder). Add/subtract
//  stays in WALK, one month per step, until the datapath's walk_more drops.
//  Reset sets the date to 1/1/2000 at once. A stalled result holds in the
//  output register; a new item waits until the walk unit is free.
// ----------------------------------------------------------------------------
module calendar_date_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // day_count[15:0], load_day[20:16],
                                     // load_month[24:21], load_year[38:25]
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_day[4:0], out_month[8:5], out_year[22:9]
  output logic        m_axis_tuser   // range_error
);

  cds_pkg::cmd_t    cmd;
  cds_pkg::status_t status;
  logic [cds_pkg::DAY_W-1:0]   out_day;
  logic [cds_pkg::MONTH_W-1:0] out_month;
  logic [cds_pkg::YEAR_W-1:0]  out_year;

  cds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cds_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (s_axis_tuser),
    .day_count_i   (s_axis_tdata[15:0]),
    .load_day_i    (s_axis_tdata[20:16]),
    .load_month_i  (s_axis_tdata[24:21]),
    .load_year_i   (s_axis_tdata[38:25]),
    .out_day_o     (out_day),
    .out_month_o   (out_month),
    .out_year_o    (out_year),
    .range_error_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_year, out_month, out_day};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_stepper testbench
// Streams load, one-day step, add/subtract and unused-mode items into the date
// stepper, predicts each result from a local Gregorian date walker and compares
// every returned date and error flag in order. Random bursts on the input side and
// changing stall patterns on the output side exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int unsigned TOTAL_ITEMS = 270;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] count;
    logic [4:0]  lday;
    logic [3:0]  lmonth;
    logic [13:0] lyear;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        err;
  } date_res_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] d;
    logic [31:0] m;
    logic [31:0] y;
  } walk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // day_count[15:0], load_day[20:16],
                                   // load_month[24:21], load_year[38:25]
  logic [2:0]  s_axis_tuser = '0;  // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // out_day[4:0], out_month[8:5], out_year[22:9]
  logic        m_axis_tuser;       // range_error

  date_cmd_t   date_items[$];
  date_res_t   expected_dates[$];
  int unsigned cal_day = 1;
  int unsigned cal_month = 1;
  int unsigned cal_year = 2000;
  int unsigned mismatch_count = 0;
  int unsigned result_idx = 0;
  int unsigned item_total = 0;
  logic        item_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;
  int unsigned stall_phase = 0;

  calendar_date_stepper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic walk_t walk_forward(int unsigned d, int unsigned m, int unsigned y,
                                         int unsigned n);
    walk_t       w;
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    dd = d + n;
    mm = m;
    yy = y;
    w.ok = 1'b1;
    while (w.ok && dd > days_in(mm, yy)) begin
      dd = dd - days_in(mm, yy);
      mm = mm + 1;
      if (mm > 12) begin
        mm = 1;
        if (yy >= cds_pkg::YEAR_MAX) w.ok = 1'b0;
        else yy = yy + 1;
      end
    end
    w.d = dd;
    w.m = mm;
    w.y = yy;
    return w;
  endfunction

  function automatic walk_t walk_backward(int unsigned d, int unsigned m, int unsigned y,
                                          int unsigned n);
    walk_t       w;
    int          dd;
    int unsigned mm;
    int unsigned yy;
    dd = int'(d) - int'(n);
    mm = m;
    yy = y;
    w.ok = 1'b1;
    while (w.ok && dd <= 0) begin
      mm = mm - 1;
      if (mm == 0) begin
        mm = 12;
        if (yy == 0) w.ok = 1'b0;
        else yy = yy - 1;
      end
      if (w.ok) dd = dd + int'(days_in(mm, yy));
    end
    w.d = dd;
    w.m = mm;
    w.y = yy;
    return w;
  endfunction

  task automatic predict_date(input date_cmd_t c);
    date_res_t r;
    walk_t     w;
    r.day = cal_day[4:0];
    r.month = cal_month[3:0];
    r.year = cal_year[13:0];
    r.err = 1'b0;
    case (c.mode)
      cds_pkg::MODE_LOAD: begin
        if (c.lmonth >= 1 && c.lmonth <= 12 && c.lyear <= cds_pkg::YEAR_MAX && c.lday >= 1 &&
            32'(c.lday) <= days_in(32'(c.lmonth), 32'(c.lyear))) begin
          cal_day = 32'(c.lday);
          cal_month = 32'(c.lmonth);
          cal_year = 32'(c.lyear);
          r.day = c.lday;
          r.month = c.lmonth;
          r.year = c.lyear;
        end else begin
          r.err = 1'b1;
        end
      end
      cds_pkg::MODE_PRE_INC, cds_pkg::MODE_POST_INC, cds_pkg::MODE_PRE_DEC,
      cds_pkg::MODE_POST_DEC: begin
        if (c.mode == cds_pkg::MODE_PRE_INC || c.mode == cds_pkg::MODE_POST_INC) begin
          w = walk_forward(cal_day, cal_month, cal_year, 1);
        end else begin
          w = walk_backward(cal_day, cal_month, cal_year, 1);
        end
        if (w.ok) begin
          cal_day = w.d;
          cal_month = w.m;
          cal_year = w.y;
          if (c.mode == cds_pkg::MODE_PRE_INC || c.mode == cds_pkg::MODE_PRE_DEC) begin
            r.day = w.d[4:0];
            r.month = w.m[3:0];
            r.year = w.y[13:0];
          end
        end else begin
          r.err = 1'b1;
        end
      end
      cds_pkg::MODE_ADD, cds_pkg::MODE_SUB: begin
        if (c.mode == cds_pkg::MODE_ADD) begin
          w = walk_forward(cal_day, cal_month, cal_year, 32'(c.count));
        end else begin
          w = walk_backward(cal_day, cal_month, cal_year, 32'(c.count));
        end
        if (w.ok) begin
          r.day = w.d[4:0];
          r.month = w.m[3:0];
          r.year = w.y[13:0];
        end else begin
          r.err = 1'b1;
        end
      end
      default: begin
      end
    endcase
    expected_dates.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d want %0d", result_idx, name, got,
                                want));
    end
  endtask

  task automatic push_cmd(input logic [2:0] mode, input int unsigned count,
                          input int unsigned d, input int unsigned m, input int unsigned y);
    date_cmd_t c;
    c.mode = mode;
    c.count = count[15:0];
    c.lday = d[4:0];
    c.lmonth = m[3:0];
    c.lyear = y[13:0];
    date_items.push_back(c);
    item_total = item_total + 1;
  endtask

  function automatic int unsigned pick_year();
    int unsigned y;
    case ($urandom_range(0, 5))
      0:       y = $urandom_range(0, 3);
      1:       y = $urandom_range(9996, 9999);
      2:       y = 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
      default: y = $urandom_range(0, 9999);
    endcase
    return y;
  endfunction

  function automatic int unsigned pick_count();
    int unsigned n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) n = $urandom_range(0, 40);
    else if (r < 80) n = $urandom_range(0, 3000);
    else if (r < 92) n = $urandom_range(0, 65535);
    else if (r < 96) n = $urandom_range(0, 1);
    else n = 65535;
    return n;
  endfunction

  task automatic push_load();
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned d;
    y = pick_year();
    m = $urandom_range(1, 12);
    len = days_in(m, y);
    d = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
    case ($urandom_range(0, 9))
      0: push_cmd(cds_pkg::MODE_LOAD, $urandom_range(0, 65535), $urandom_range(len + 1, 31),
                  m, y);
      1: push_cmd(cds_pkg::MODE_LOAD, $urandom_range(0, 65535), d, $urandom_range(13, 15), y);
      2: push_cmd(cds_pkg::MODE_LOAD, $urandom_range(0, 65535), d, m,
                  $urandom_range(10000, 16383));
      default: push_cmd(cds_pkg::MODE_LOAD, $urandom_range(0, 65535), d, m, y);
    endcase
  endtask

  task automatic push_step();
    logic [2:0] mode;
    mode = 3'($urandom_range(1, 6));
    push_cmd(mode, (mode == cds_pkg::MODE_ADD || mode == cds_pkg::MODE_SUB) ? pick_count() :
             $urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 15),
             $urandom_range(0, 16383));
  endtask

  always @(negedge clk_i) begin : drive_proc
    date_cmd_t c;
    if (rst_ni && (!s_axis_tvalid || item_taken)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (date_items.size() > 0) begin
        c = date_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.mode;
        s_axis_tdata <= {1'b0, c.lyear, c.lmonth, c.lday, c.count};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink_proc
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_phase < 3);
    endcase
  end

  always @(posedge clk_i) begin : monitor_proc
    date_res_t want;
    date_cmd_t c;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    result_idx));
        end else begin
          want = expected_dates.pop_front();
          check_field("day", 32'(m_axis_tdata[4:0]), 32'(want.day));
          check_field("month", 32'(m_axis_tdata[8:5]), 32'(want.month));
          check_field("year", 32'(m_axis_tdata[22:9]), 32'(want.year));
          check_field("range_error", 32'(m_axis_tuser), 32'(want.err));
        end
        result_idx <= result_idx + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c.mode = s_axis_tuser;
        c.count = s_axis_tdata[15:0];
        c.lday = s_axis_tdata[20:16];
        c.lmonth = s_axis_tdata[24:21];
        c.lyear = s_axis_tdata[38:25];
        predict_date(c);
      end
      item_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  initial begin
    #40_000_000;
    $display("calendar_date_stepper verification failed");
    $finish;
  end

  initial begin
    push_cmd(MODE_UNUSED, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_POST_DEC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_PRE_INC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_LOAD, 0, 29, 2, 2000);
    push_cmd(cds_pkg::MODE_LOAD, 0, 29, 2, 1900);
    push_cmd(cds_pkg::MODE_LOAD, 0, 31, 4, 2021);
    push_cmd(cds_pkg::MODE_LOAD, 0, 0, 6, 2021);
    push_cmd(cds_pkg::MODE_LOAD, 0, 1, 0, 2021);
    push_cmd(cds_pkg::MODE_LOAD, 0, 1, 15, 2021);
    push_cmd(cds_pkg::MODE_LOAD, 0, 1, 1, 10000);
    push_cmd(cds_pkg::MODE_LOAD, 65535, 31, 15, 16383);
    push_cmd(cds_pkg::MODE_LOAD, 0, 31, 12, 9999);
    push_cmd(cds_pkg::MODE_PRE_INC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_POST_INC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_ADD, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_ADD, 1, 0, 0, 0);
    push_cmd(cds_pkg::MODE_LOAD, 0, 1, 1, 0);
    push_cmd(cds_pkg::MODE_PRE_DEC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_POST_DEC, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_SUB, 0, 0, 0, 0);
    push_cmd(cds_pkg::MODE_SUB, 65535, 0, 0, 0);
    push_cmd(cds_pkg::MODE_LOAD, 0, 29, 2, 0);
    push_cmd(cds_pkg::MODE_LOAD, 0, 28, 2, 2023);
    push_cmd(cds_pkg::MODE_ADD, 1, 0, 0, 0);
    push_cmd(cds_pkg::MODE_LOAD, 0, 15, 6, 5000);
    push_cmd(cds_pkg::MODE_ADD, 65535, 0, 0, 0);
    push_cmd(cds_pkg::MODE_SUB, 65535, 0, 0, 0);
    push_cmd(MODE_UNUSED, 65535, 31, 15, 16383);
    while (item_total < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        push_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 65535), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 16383));
      end else begin
        push_load();
        repeat ($urandom_range(1, 6)) push_step();
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (date_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_dates.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
    end
    if (mismatch_count == 0) begin
      $display("calendar_date_stepper verification clean");
    end else begin
      $display("calendar_date_stepper verification failed");
    end
    $finish;
  end

endmodule
